// ----- hw/rtl/rfr_pkg.sv -----
// Shared types and constants of the reader frame receiver.
package rfr_pkg;

  // Register indexes on the configuration port.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_BYTE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_END_BYTE    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH  = 2'd2;
  localparam int unsigned CfgDataW = 16;

  // Reset values of the configuration registers.
  localparam logic [7:0]  HEADER_BYTE_RST = 8'hBB;
  localparam logic [7:0]  END_BYTE_RST    = 8'h7E;
  localparam logic [15:0] MAX_LENGTH_RST  = 16'd256;

  // Command that marks an error response.
  localparam logic [7:0] ERROR_CMD = 8'hFF;

  // Kind of a result.
  typedef enum logic {
    KIND_PARAM   = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  // Frame status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ERR_RESP  = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_BAD_END   = 3'd3,
    ST_BAD_CHECK = 3'd4
  } status_e;

  // Parser phase, one-hot.
  typedef enum logic [7:0] {
    PH_HUNT  = 8'b0000_0001,
    PH_TYPE  = 8'b0000_0010,
    PH_CMD   = 8'b0000_0100,
    PH_LENHI = 8'b0000_1000,
    PH_LENLO = 8'b0001_0000,
    PH_PARAM = 8'b0010_0000,
    PH_CHECK = 8'b0100_0000,
    PH_END   = 8'b1000_0000
  } phase_e;

endpackage

// ----- hw/rtl/reader_frame_receiver.sv -----
// Byte-serial parser for a reader's response frames with an 8-bit sum checksum.
//
// The block takes one received byte per transfer and accepts a byte in every
// clock cycle that the output is not stalled: all the work for a byte is a
// phase update, an 8-bit add and a few compares, done in the cycle of the
// transfer, and the result is written into a single output register. A new
// byte is taken whenever that register is empty or is being emptied in the
// same cycle, so the sustained rate is one byte per cycle while results are taken.
// Bytes are dropped until the header byte appears; then come type, command,
// a big-endian 16-bit parameter length, the parameter bytes, a checksum byte
// and an end byte. Each parameter byte gives a result of kind 0 carrying its
// index; the frame closes with one verdict of kind 1. A length above the
// configured limit gives an immediate bad-length verdict and the block hunts
// for a header again. The verdict reports, in order of priority, a bad end
// byte, a checksum mismatch, an error response (command 0xFF, whose first
// parameter becomes the sticky error code) or success. A header byte inside a
// frame is ordinary data. Configuration writes take effect at once and are
// meant to be made while the block is idle.
module reader_frame_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port
  input  logic                          cfg_we_i,
  input  logic [rfr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rfr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          result_kind_o,
  output logic [7:0]                    param_byte_o,
  output logic [15:0]                   param_index_o,
  output logic [7:0]                    frame_type_o,
  output logic [7:0]                    frame_cmd_o,
  output logic [15:0]                   param_length_o,
  output logic [2:0]                    status_o,
  output logic [7:0]                    error_code_o
);

  // Configuration registers.
  logic [7:0]  header_byte_q;
  logic [7:0]  end_byte_q;
  logic [15:0] max_length_q;

  // Frame state.
  rfr_pkg::phase_e phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] length_q, length_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  first_param_q, first_param_d;
  logic [7:0]  check_q, check_d;
  logic [7:0]  last_error_q, last_error_d;

  // Output register.
  logic              out_valid_q;
  rfr_pkg::kind_e    kind_q, kind_d;
  logic [7:0]        pbyte_q, pbyte_d;
  logic [15:0]       pidx_q, pidx_d;
  logic [7:0]        otype_q;
  logic [7:0]        ocmd_q;
  logic [15:0]       olength_q;
  rfr_pkg::status_e  status_q, status_d;
  logic [7:0]        oerror_q;

  logic        in_xfer;
  logic        emit;
  logic [15:0] count_inc;
  logic [15:0] length_lo;

  // The output register frees up in the same cycle that its result is taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign count_inc = count_q + 16'd1;
  assign length_lo = {length_q[15:8], rx_byte_i};

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_byte_q <= rfr_pkg::HEADER_BYTE_RST;
      end_byte_q    <= rfr_pkg::END_BYTE_RST;
      max_length_q  <= rfr_pkg::MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rfr_pkg::CFG_HEADER_BYTE: header_byte_q <= cfg_wdata_i[7:0];
        rfr_pkg::CFG_END_BYTE:    end_byte_q    <= cfg_wdata_i[7:0];
        rfr_pkg::CFG_MAX_LENGTH:  max_length_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next state of the parser for the byte on the input, and the result that
  // it gives, if any. The fields copied from the frame registers are taken
  // from their next values so that a verdict shows the frame as updated.
  always_comb begin
    phase_d       = phase_q;
    type_d        = type_q;
    cmd_d         = cmd_q;
    length_d      = length_q;
    count_d       = count_q;
    sum_d         = sum_q;
    first_param_d = first_param_q;
    check_d       = check_q;
    last_error_d  = last_error_q;
    emit          = 1'b0;
    kind_d        = rfr_pkg::KIND_VERDICT;
    pbyte_d       = 8'd0;
    pidx_d        = 16'd0;
    status_d      = rfr_pkg::ST_OK;

    case (phase_q)
      rfr_pkg::PH_HUNT: begin
        if (rx_byte_i == header_byte_q) begin
          sum_d   = 8'd0;
          count_d = 16'd0;
          phase_d = rfr_pkg::PH_TYPE;
        end
      end
      rfr_pkg::PH_TYPE: begin
        type_d  = rx_byte_i;
        sum_d   = sum_q + rx_byte_i;
        phase_d = rfr_pkg::PH_CMD;
      end
      rfr_pkg::PH_CMD: begin
        cmd_d   = rx_byte_i;
        sum_d   = sum_q + rx_byte_i;
        phase_d = rfr_pkg::PH_LENHI;
      end
      rfr_pkg::PH_LENHI: begin
        length_d = {rx_byte_i, 8'd0};
        sum_d    = sum_q + rx_byte_i;
        phase_d  = rfr_pkg::PH_LENLO;
      end
      rfr_pkg::PH_LENLO: begin
        length_d = length_lo;
        sum_d    = sum_q + rx_byte_i;
        count_d  = 16'd0;
        if (length_lo > max_length_q) begin
          phase_d  = rfr_pkg::PH_HUNT;
          emit     = 1'b1;
          status_d = rfr_pkg::ST_BAD_LEN;
        end else if (length_lo == 16'd0) begin
          phase_d = rfr_pkg::PH_CHECK;
        end else begin
          phase_d = rfr_pkg::PH_PARAM;
        end
      end
      rfr_pkg::PH_PARAM: begin
        if (count_q == 16'd0) begin
          first_param_d = rx_byte_i;
        end
        sum_d   = sum_q + rx_byte_i;
        emit    = 1'b1;
        kind_d  = rfr_pkg::KIND_PARAM;
        pbyte_d = rx_byte_i;
        pidx_d  = count_q;
        count_d = count_inc;
        // The count never passes the length, so reaching it is equality.
        if (count_inc == length_q) begin
          phase_d = rfr_pkg::PH_CHECK;
        end
      end
      rfr_pkg::PH_CHECK: begin
        check_d = rx_byte_i;
        phase_d = rfr_pkg::PH_END;
      end
      rfr_pkg::PH_END: begin
        emit    = 1'b1;
        phase_d = rfr_pkg::PH_HUNT;
        if (rx_byte_i != end_byte_q) begin
          status_d = rfr_pkg::ST_BAD_END;
        end else if (check_q != sum_q) begin
          status_d = rfr_pkg::ST_BAD_CHECK;
        end else if (cmd_q == rfr_pkg::ERROR_CMD) begin
          status_d = rfr_pkg::ST_ERR_RESP;
          // An error response without parameters leaves the code alone.
          if (length_q != 16'd0) begin
            last_error_d = first_param_q;
          end
        end else begin
          status_d = rfr_pkg::ST_OK;
        end
      end
      default: begin
        phase_d = rfr_pkg::PH_HUNT;
      end
    endcase
  end

  // Frame state registers, updated on every input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= rfr_pkg::PH_HUNT;
      type_q        <= 8'd0;
      cmd_q         <= 8'd0;
      length_q      <= 16'd0;
      count_q       <= 16'd0;
      sum_q         <= 8'd0;
      first_param_q <= 8'd0;
      check_q       <= 8'd0;
      last_error_q  <= 8'd0;
    end else if (in_xfer) begin
      phase_q       <= phase_d;
      type_q        <= type_d;
      cmd_q         <= cmd_d;
      length_q      <= length_d;
      count_q       <= count_d;
      sum_q         <= sum_d;
      first_param_q <= first_param_d;
      check_q       <= check_d;
      last_error_q  <= last_error_d;
    end
  end

  // Output valid: set by a transfer that gives a result, cleared when the
  // result is taken and nothing replaces it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      kind_q    <= kind_d;
      pbyte_q   <= pbyte_d;
      pidx_q    <= pidx_d;
      otype_q   <= type_d;
      ocmd_q    <= cmd_d;
      olength_q <= length_d;
      status_q  <= status_d;
      oerror_q  <= last_error_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign param_byte_o   = pbyte_q;
  assign param_index_o  = pidx_q;
  assign frame_type_o   = otype_q;
  assign frame_cmd_o    = ocmd_q;
  assign param_length_o = olength_q;
  assign status_o       = status_q;
  assign error_code_o   = oerror_q;

  // A parameter result always carries an ok status.
  a_param_status_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == rfr_pkg::KIND_PARAM) |-> status_q == rfr_pkg::ST_OK)
    else $error("parameter result with a non-ok status");

  // While parameters are read, the count stays below a nonzero length.
  a_param_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rfr_pkg::PH_PARAM) |-> (length_q != 16'd0 && count_q < length_q))
    else $error("parameter count outside the frame length");

  // The sticky error code only moves with an error-response verdict.
  a_error_code_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_error_q != $past(last_error_q)) |->
      (out_valid_q && kind_q == rfr_pkg::KIND_VERDICT && status_q == rfr_pkg::ST_ERR_RESP))
    else $error("error code changed without an error response");

  // Input is held off only while a result waits to be taken.
  a_ready_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_q && !out_ready_i))
    else $error("input stalled with a free output register");

endmodule
